// ===== rtl/sptd_pkg.sv =====
`timescale 1ns / 1ps
package sptd_pkg;

  // image and palette limits
  localparam int MAX_WIDTH     = 512;
  localparam int MAX_HEIGHT    = 512;
  localparam int PALETTE_DEPTH = 256;

  // fixed field widths
  localparam int DIM_W     = 10;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W     = 18;
  localparam int COL_W     = 5;
  localparam int ROW_W     = 3;

  // derived widths
  localparam int PAL_AW  = $clog2(PALETTE_DEPTH);
  localparam int FILL_W  = $clog2(PALETTE_DEPTH + 1);
  localparam int WS_W    = $clog2(MAX_WIDTH + 1);
  localparam int HS_W    = $clog2(MAX_HEIGHT + 1);
  localparam int TX_W    = $clog2(MAX_WIDTH / 4 + 1);
  localparam int TY_W    = $clog2(MAX_HEIGHT / 8 + 1);
  localparam int X_W     = $clog2(MAX_WIDTH + 32);
  localparam int Y_W     = HS_W;
  localparam int PROD_W  = Y_W + WS_W + 1;

  // pixel queue
  localparam int FIFO_DEPTH = 8;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    FMT_ARGB1555,
    FMT_RGB655,
    FMT_ARGB4444,
    FMT_ARGB8888
  } color_fmt_t;

  localparam logic [1:0] LAYOUT_DIRECT = 2'd0;
  localparam logic [1:0] LAYOUT_PAL4   = 2'd1;
  localparam logic [1:0] LAYOUT_PAL8   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COLOR_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

  localparam logic [DIM_W-1:0] RESET_DIM = DIM_W'(512);

  typedef struct packed {
    logic [PIX_W-1:0] index;
    logic [31:0]      rgba;   // {a, b, g, r}
    logic             last;
    logic             done;
  } pixel_t;

  typedef struct packed {
    logic   valid;
    pixel_t pix;
  } pix_push_t;

  // 8-bit index folded onto the palette depth
  typedef logic [255:0][PAL_AW-1:0] idx_tab_t;

  function automatic idx_tab_t make_idx_tab();
    idx_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = PAL_AW'(i % PALETTE_DEPTH);
    end
    return tab;
  endfunction

  localparam idx_tab_t IDX_MOD_TAB = make_idx_tab();

  // 16-bit formats scaled by 8 (5-bit) or 17 (4-bit); 655 keeps only the low 5 red bits
  function automatic logic [31:0] expand_color(logic [1:0] fmt, logic [31:0] w);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    r = '0;
    g = '0;
    b = '0;
    a = '0;
    unique case (color_fmt_t'(fmt))
      FMT_ARGB1555: begin
        r = {w[4:0], 3'b000};
        g = {w[9:5], 3'b000};
        b = {w[14:10], 3'b000};
        a = w[15] ? 8'hFF : 8'h00;
      end
      FMT_RGB655: begin
        r = {w[4:0], 3'b000};
        g = {w[10:6], 3'b000};
        b = {w[15:11], 3'b000};
        a = 8'hFF;
      end
      FMT_ARGB4444: begin
        r = {w[3:0], w[3:0]};
        g = {w[7:4], w[7:4]};
        b = {w[11:8], w[11:8]};
        a = {w[15:12], w[15:12]};
      end
      FMT_ARGB8888: begin
        r = w[7:0];
        g = w[15:8];
        b = w[23:16];
        a = w[31:24];
      end
      default: begin
        r = w[7:0];
        g = w[15:8];
        b = w[23:16];
        a = w[31:24];
      end
    endcase
    return {a, b, g, r};
  endfunction

endpackage

// ===== rtl/sptd_pix_fifo.sv =====
`timescale 1ns / 1ps
module sptd_pix_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  sptd_pkg::pix_push_t       push0,
  input  sptd_pkg::pix_push_t       push1,
  input  logic                      pop,
  output sptd_pkg::pixel_t          head,
  output logic [sptd_pkg::FCNT_W-1:0] count
);
  import sptd_pkg::*;

  pixel_t             mem [FIFO_DEPTH];
  logic [FPTR_W-1:0]  wr_ptr;
  logic [FPTR_W-1:0]  rd_ptr;
  logic [FCNT_W-1:0]  n_push;

  // push1 only rides along with push0
  assign n_push = FCNT_W'(push0.valid) + FCNT_W'(push1.valid);
  assign head   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push0.valid) begin
      mem[wr_ptr] <= push0.pix;
    end
    if (push1.valid) begin
      mem[wr_ptr + FPTR_W'(1)] <= push1.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FPTR_W'(n_push);
      rd_ptr <= rd_ptr + FPTR_W'(pop);
      count  <= count + n_push - FCNT_W'(pop);
    end
  end

endmodule

// ===== rtl/swizzled_palette_texture_decoder_top.sv =====
`timescale 1ns / 1ps
// An accepted input word passes the lookup stage registers, then the pixel queue.
// Throughput: 1 input word per cycle in the direct and 8-bit palette layouts
//   while in_stall is low; the 4-bit layout is paced by the one-pixel-per-cycle output.
// Palette RAM: 1 write and 2 reads per cycle, read data registered.
// Reset (synchronous): clears tile position, fill count, frame flag and pixel
//   queue, loads register defaults; palette RAM contents are kept, no sweep.
module swizzled_palette_texture_decoder_top (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_write_en,
  input  logic [sptd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sptd_pkg::CFG_W-1:0]      cfg_data,
  // input words
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            frame_start,
  input  logic [31:0]                     raw_word,
  // output words
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sptd_pkg::PIX_W-1:0]      pixel_index,
  output logic [7:0]                      red,
  output logic [7:0]                      green,
  output logic [7:0]                      blue,
  output logic [7:0]                      alpha,
  output logic                            last_of_item,
  output logic                            frame_done
);
  import sptd_pkg::*;

  // ---------------- configuration registers ----------------
  logic [1:0]       color_format;
  logic [1:0]       layout_mode;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_format <= FMT_ARGB8888;
      layout_mode  <= LAYOUT_PAL8;
      image_width  <= RESET_DIM;
      image_height <= RESET_DIM;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_COLOR_FORMAT: color_format <= cfg_data[1:0];
        REG_LAYOUT_MODE:  layout_mode  <= cfg_data[1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- frame walk state ----------------
  logic [FILL_W-1:0] fill_count;
  logic [COL_W-1:0]  tile_column;
  logic [ROW_W-1:0]  tile_row;
  logic [TX_W-1:0]   tile_x;
  logic [TY_W-1:0]   tile_y;
  logic              frame_complete;

  logic [FILL_W-1:0] fill_count_next;
  logic [COL_W-1:0]  tile_column_next;
  logic [ROW_W-1:0]  tile_row_next;
  logic [TX_W-1:0]   tile_x_next;
  logic [TY_W-1:0]   tile_y_next;
  logic              frame_complete_next;

  logic in_accept;
  logic out_accept;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  // frame_start restarts the walk before this word is looked at
  logic [FILL_W-1:0] eff_fill;
  logic [COL_W-1:0]  eff_col;
  logic [ROW_W-1:0]  eff_row;
  logic [TX_W-1:0]   eff_tx;
  logic [TY_W-1:0]   eff_ty;
  logic              eff_done;

  assign eff_fill = frame_start ? '0 : fill_count;
  assign eff_col  = frame_start ? '0 : tile_column;
  assign eff_row  = frame_start ? '0 : tile_row;
  assign eff_tx   = frame_start ? '0 : tile_x;
  assign eff_ty   = frame_start ? '0 : tile_y;
  assign eff_done = frame_start ? 1'b0 : frame_complete;

  // layout decode; the unused code behaves as the 8-bit palette
  logic              is_direct;
  logic              is_pal4;
  logic [FILL_W-1:0] need;
  logic [5:0]        seg_w;
  logic [2:0]        seg_shift;
  logic [1:0]        step;

  assign is_direct = (layout_mode == LAYOUT_DIRECT);
  assign is_pal4   = (layout_mode == LAYOUT_PAL4);

  always_comb begin
    priority if (is_direct) begin
      need      = '0;
      seg_w     = 6'd4;
      seg_shift = 3'd2;
      step      = 2'd1;
    end else if (is_pal4) begin
      need      = FILL_W'(16);
      seg_w     = 6'd32;
      seg_shift = 3'd5;
      step      = 2'd2;
    end else begin
      need      = FILL_W'(PALETTE_DEPTH);
      seg_w     = 6'd16;
      seg_shift = 3'd4;
      step      = 2'd1;
    end
  end

  // image size clipped to the supported maximum, then counted in tiles
  logic [WS_W-1:0] w_sat;
  logic [HS_W-1:0] h_sat;
  logic [TX_W-1:0] segs_x;
  logic [TY_W-1:0] segs_y;

  assign w_sat  = (int'(image_width) > MAX_WIDTH) ? WS_W'(MAX_WIDTH) : WS_W'(image_width);
  assign h_sat  = (int'(image_height) > MAX_HEIGHT) ? HS_W'(MAX_HEIGHT) : HS_W'(image_height);
  assign segs_x = TX_W'(w_sat >> seg_shift);
  assign segs_y = TY_W'(h_sat >> 3);

  logic loading;
  logic off_grid;
  logic emit_ok;

  assign loading  = !is_direct && (eff_fill < need);
  assign off_grid = (eff_tx >= segs_x) || (eff_ty >= segs_y);
  assign emit_ok  = !eff_done && !loading && !off_grid;

  // position of the first pixel of this word
  logic [X_W-1:0] pos_x;
  logic [Y_W-1:0] pos_y;

  assign pos_x = X_W'(eff_col) + (X_W'(eff_tx) << seg_shift);
  assign pos_y = Y_W'({eff_ty, eff_row});

  // tile walk: column, then row in tile, then tile across, then tile down
  logic [COL_W:0] col_sum;
  assign col_sum = {1'b0, eff_col} + (COL_W + 1)'(step);

  always_comb begin
    fill_count_next     = eff_fill;
    tile_column_next    = eff_col;
    tile_row_next       = eff_row;
    tile_x_next         = eff_tx;
    tile_y_next         = eff_ty;
    frame_complete_next = eff_done;
    if (!eff_done) begin
      priority if (loading) begin
        fill_count_next = eff_fill + FILL_W'(1);
      end else if (off_grid) begin
        frame_complete_next = 1'b1;
      end else begin
        tile_column_next = col_sum[COL_W-1:0];
        if (col_sum >= (COL_W + 1)'(seg_w)) begin
          tile_column_next = '0;
          tile_row_next    = eff_row + ROW_W'(1);
          if (eff_row == '1) begin
            tile_row_next = '0;
            tile_x_next   = eff_tx + TX_W'(1);
            if (eff_tx + TX_W'(1) >= segs_x) begin
              tile_x_next = '0;
              tile_y_next = eff_ty + TY_W'(1);
              if (eff_ty + TY_W'(1) >= segs_y) begin
                frame_complete_next = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count     <= '0;
      tile_column    <= '0;
      tile_row       <= '0;
      tile_x         <= '0;
      tile_y         <= '0;
      frame_complete <= 1'b0;
    end else if (in_accept) begin
      fill_count     <= fill_count_next;
      tile_column    <= tile_column_next;
      tile_row       <= tile_row_next;
      tile_x         <= tile_x_next;
      tile_y         <= tile_y_next;
      frame_complete <= frame_complete_next;
    end
  end

  // ---------------- palette RAM ----------------
  // Entries are stored already expanded. Loads always finish before the
  // lookups of a frame start, and a write is already stored when any later
  // read samples the RAM, so no bypass path is needed.
  logic [31:0]       pal_mem [PALETTE_DEPTH];
  logic              pal_we;
  logic              pal_re;
  logic [PAL_AW-1:0] pal_waddr;
  logic [PAL_AW-1:0] pal_raddr0;
  logic [PAL_AW-1:0] pal_raddr1;
  logic [31:0]       pal_rd0;
  logic [31:0]       pal_rd1;
  logic [31:0]       word_rgba;

  assign word_rgba  = expand_color(color_format, raw_word);
  assign pal_we     = in_accept && !eff_done && loading;
  assign pal_re     = in_accept && emit_ok && !is_direct;
  assign pal_waddr  = PAL_AW'(eff_fill);
  assign pal_raddr0 = is_pal4 ? PAL_AW'(raw_word[3:0]) : IDX_MOD_TAB[raw_word[7:0]];
  assign pal_raddr1 = PAL_AW'(raw_word[7:4]);

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[pal_waddr] <= word_rgba;
    end
    if (pal_re) begin
      pal_rd0 <= pal_mem[pal_raddr0];
      pal_rd1 <= pal_mem[pal_raddr1];
    end
  end

  // ---------------- lookup stage ----------------
  logic            s1_valid;
  logic            s1_pal4;
  logic            s1_use_pal;
  logic            s1_done;
  logic [31:0]     s1_rgba;
  logic [X_W-1:0]  s1_x;
  logic [Y_W-1:0]  s1_y;
  logic [WS_W-1:0] s1_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept && emit_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pal4    <= is_pal4;
      s1_use_pal <= !is_direct;
      s1_done    <= frame_complete_next;
      s1_rgba    <= word_rgba;
      s1_x       <= pos_x;
      s1_y       <= pos_y;
      s1_w       <= w_sat;
    end
  end

  // linear address: row times width plus column
  logic [PROD_W-1:0] base;
  assign base = PROD_W'(s1_y) * PROD_W'(s1_w) + PROD_W'(s1_x);

  pix_push_t push0;
  pix_push_t push1;

  always_comb begin
    push0.valid     = s1_valid;
    push0.pix.index = PIX_W'(base);
    push0.pix.rgba  = s1_use_pal ? pal_rd0 : s1_rgba;
    push0.pix.last  = !s1_pal4;
    push0.pix.done  = !s1_pal4 && s1_done;
    push1.valid     = s1_valid && s1_pal4;
    push1.pix.index = PIX_W'(base + PROD_W'(1));
    push1.pix.rgba  = pal_rd1;
    push1.pix.last  = 1'b1;
    push1.pix.done  = s1_done;
  end

  // ---------------- pixel queue ----------------
  pixel_t            head;
  logic [FCNT_W-1:0] fifo_count;

  sptd_pix_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push0 (push0),
    .push1 (push1),
    .pop   (out_accept),
    .head  (head),
    .count (fifo_count)
  );

  // Room for the word in the lookup stage and one more word, two pixels each.
  logic [FCNT_W:0] pending;
  assign pending  = {1'b0, fifo_count} + (s1_valid ? (FCNT_W + 1)'(2) : '0);
  assign in_stall = pending > (FCNT_W + 1)'(FIFO_DEPTH - 2);

  assign out_valid    = (fifo_count != '0);
  assign pixel_index  = head.index;
  assign red          = head.rgba[7:0];
  assign green        = head.rgba[15:8];
  assign blue         = head.rgba[23:16];
  assign alpha        = head.rgba[31:24];
  assign last_of_item = head.last;
  assign frame_done   = head.done;

  // ---------------- checks ----------------
  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= FCNT_W'(FIFO_DEPTH))
    else $error("pixel queue overflow");

  a_done_frame_silent: assert property (@(posedge clk) disable iff (rst)
    (in_accept && frame_complete && !frame_start) |=> !s1_valid)
    else $error("word after frame end produced pixels");

  a_lookup_reaches_out: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> out_valid)
    else $error("looked-up pixel not queued");

endmodule
